// ===== rtl/sse_pkg.sv =====
// Shared types and constants for the search stack engine.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_SEARCH = 3'd2,
        OP_MIDDLE = 3'd3,
        OP_LIST   = 3'd4
    } sse_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } sse_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } sse_state_t;

    typedef enum logic [1:0] {
        U_INC,
        U_DEC,
        U_MID
    } sse_uop_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } sse_mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sse_unit.sv =====
// Shared count arithmetic and word compare unit.
`timescale 1ns / 1ps
`default_nettype none

module sse_unit #(
    parameter int CW = 5
) (
    input  var sse_pkg::sse_uop_t          uop,
    input  var logic [CW-1:0]              a_in,
    input  var logic signed [sse_pkg::DATA_W-1:0] entry,
    input  var logic signed [sse_pkg::DATA_W-1:0] key,
    output var logic [CW-1:0]              res,
    output var logic                       eq
);

    always_comb begin
        unique case (uop)
            sse_pkg::U_INC: res = a_in + CW'(1);
            sse_pkg::U_DEC: res = a_in - CW'(1);
            sse_pkg::U_MID: res = a_in - CW'(1) - (a_in >> 1);
            default:        res = a_in;
        endcase
    end

    assign eq = (entry == key);

endmodule

`default_nettype wire

// ===== rtl/sse_mem.sv =====
// Stack word store: one write and one registered read per cycle at one shared address.
`timescale 1ns / 1ps
`default_nettype none

module sse_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  var logic                              aclk,
    input  var sse_pkg::sse_mem_ctl_t             ctl,
    input  var logic [AW-1:0]                     addr,
    input  var logic signed [sse_pkg::DATA_W-1:0] wr_data,
    output var logic signed [sse_pkg::DATA_W-1:0] rd_data
);

    logic signed [sse_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [sse_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/sse_ctrl.sv =====
// Sequencer: decodes operations, walks the store and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  var logic                              aclk,
    input  var logic                              aresetn,
    input  var logic                              s_valid,
    output var logic                              s_ready,
    input  var logic [2:0]                        s_opcode,
    input  var logic signed [sse_pkg::DATA_W-1:0] s_value,
    output var logic                              m_valid,
    input  var logic                              m_ready,
    output var logic [1:0]                        m_status,
    output var logic                              m_found,
    output var logic signed [sse_pkg::DATA_W-1:0] m_data,
    output var logic                              m_last,
    output var sse_pkg::sse_mem_ctl_t             mem_ctl,
    output var logic [AW-1:0]                     mem_addr,
    output var logic signed [sse_pkg::DATA_W-1:0] mem_wdata,
    input  var logic signed [sse_pkg::DATA_W-1:0] rd_data
);

    sse_pkg::sse_state_t state_reg, state_next;
    sse_pkg::sse_op_t    op_reg, op_next;
    logic signed [sse_pkg::DATA_W-1:0] key_reg, key_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          hit_reg, hit_next;
    logic          rdv_reg, rdv_next;
    logic          list_reg, list_next;

    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic          m_found_reg;
    logic signed [sse_pkg::DATA_W-1:0] m_data_reg;
    logic          m_last_reg;

    logic                 out_free;
    logic                 emit;
    sse_pkg::sse_status_t e_status;
    logic                 e_found;
    logic signed [sse_pkg::DATA_W-1:0] e_data;
    logic                 e_last;
    logic                 empty;
    logic                 full;

    sse_pkg::sse_uop_t uop;
    logic [CW-1:0]     ua;
    logic [CW-1:0]     ures;
    logic              ueq;

    sse_unit #(.CW(CW)) u_unit (
        .uop   (uop),
        .a_in  (ua),
        .entry (rd_data),
        .key   (key_reg),
        .res   (ures),
        .eq    (ueq)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CW'(DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sse_pkg::S_IDLE;
            fill_reg    <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rdv_reg   <= rdv_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        ptr_reg  <= ptr_next;
        hit_reg  <= hit_next;
        list_reg <= list_next;
        if (emit) begin
            m_status_reg <= e_status;
            m_found_reg  <= e_found;
            m_data_reg   <= e_data;
            m_last_reg   <= e_last;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        hit_next   = hit_reg;
        list_next  = list_reg;
        s_ready    = 1'b0;
        mem_ctl    = '0;
        mem_addr   = fill_reg[AW-1:0];
        mem_wdata  = key_reg;
        uop        = sse_pkg::U_INC;
        ua         = fill_reg;
        emit       = 1'b0;
        e_status   = sse_pkg::ST_OK;
        e_found    = 1'b0;
        e_data     = '0;
        e_last     = 1'b1;

        unique case (state_reg)
            sse_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = sse_pkg::sse_op_t'(s_opcode);
                    key_next   = s_value;
                    state_next = sse_pkg::S_EXEC;
                end
            end

            sse_pkg::S_EXEC: begin
                unique case (op_reg)
                    sse_pkg::OP_PUSH: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = sse_pkg::S_IDLE;
                            if (full) begin
                                e_status = sse_pkg::ST_FULL;
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                                uop           = sse_pkg::U_INC;
                                fill_next     = ures;
                            end
                        end
                    end
                    sse_pkg::OP_POP: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = sse_pkg::S_IDLE;
                            if (empty) begin
                                e_status = sse_pkg::ST_EMPTY;
                            end else begin
                                uop       = sse_pkg::U_DEC;
                                fill_next = ures;
                            end
                        end
                    end
                    sse_pkg::OP_SEARCH, sse_pkg::OP_MIDDLE, sse_pkg::OP_LIST: begin
                        if (empty) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                e_status   = sse_pkg::ST_EMPTY;
                                state_next = sse_pkg::S_IDLE;
                            end
                        end else if (op_reg == sse_pkg::OP_SEARCH) begin
                            // start the walk from the bottom entry
                            mem_ctl.rd_en = 1'b1;
                            mem_addr      = '0;
                            ptr_next      = CW'(1);
                            hit_next      = 1'b0;
                            state_next    = sse_pkg::S_SCAN;
                        end else begin
                            uop           = (op_reg == sse_pkg::OP_LIST) ?
                                            sse_pkg::U_DEC : sse_pkg::U_MID;
                            mem_ctl.rd_en = 1'b1;
                            mem_addr      = ures[AW-1:0];
                            ptr_next      = ures;
                            list_next     = (op_reg == sse_pkg::OP_LIST);
                            state_next    = sse_pkg::S_EMIT;
                        end
                    end
                    default: begin
                        // unused opcode: drop silently
                        state_next = sse_pkg::S_IDLE;
                    end
                endcase
            end

            sse_pkg::S_SCAN: begin
                ua  = ptr_reg;
                uop = sse_pkg::U_INC;
                if (ptr_reg != fill_reg) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = ptr_reg[AW-1:0];
                    ptr_next      = ures;
                end
                if (rdv_reg && ueq) begin
                    hit_next = 1'b1;
                end
                if ((ptr_reg == fill_reg) && !rdv_reg && out_free) begin
                    emit       = 1'b1;
                    e_found    = hit_reg;
                    state_next = sse_pkg::S_IDLE;
                end
            end

            sse_pkg::S_EMIT: begin
                ua  = ptr_reg;
                uop = sse_pkg::U_DEC;
                if (out_free) begin
                    emit   = 1'b1;
                    e_data = rd_data;
                    e_last = !list_reg || (ptr_reg == '0);
                    if (e_last) begin
                        state_next = sse_pkg::S_IDLE;
                    end else begin
                        // fetch the next entry down while this one leaves
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = ures[AW-1:0];
                        ptr_next      = ures;
                    end
                end
            end

            default: begin
                state_next = sse_pkg::S_IDLE;
            end
        endcase

        rdv_next = mem_ctl.rd_en;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/search_stack_engine_top.sv =====
// Search stack engine top: LIFO of signed words with search, middle and listing.
//
//  channel   direction  tdata              tuser                      tlast
//  s_axis    in         operand_value      opcode                     -
//  m_axis    out        entry_data         status, found              last
//
// Operations: push and pop finish in the execute state; search reads one store entry
// per cycle through the single read port feeding the shared comparator; list gives
// one entry per cycle from the same port while the result register is free.
// Reset: aresetn clears the fill count, sequencer state and result valid flag; the
// word store itself is not cleared and needs no clearing pass.
// Stalls: a held result stalls the sequencer only when a new result must be written;
// s_axis_tready is high only while the sequencer is idle.
`timescale 1ns / 1ps
`default_nettype none

module search_stack_engine_top #(
    parameter int DEPTH = sse_pkg::DEPTH_DEF
) (
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_axis_tvalid,
    output var logic        s_axis_tready,
    input  var logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  var logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output var logic        m_axis_tvalid,
    input  var logic        m_axis_tready,
    output var logic [31:0] m_axis_tdata,   // [31:0] entry_data
    output var logic [2:0]  m_axis_tuser,   // [1:0] status, [2] found
    output var logic        m_axis_tlast    // last result of the transaction
);

    // address and count widths follow the depth
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sse_pkg::sse_mem_ctl_t             mem_ctl;
    logic [AW-1:0]                     mem_addr;
    logic signed [sse_pkg::DATA_W-1:0] mem_wdata;
    logic signed [sse_pkg::DATA_W-1:0] rd_data;
    logic signed [sse_pkg::DATA_W-1:0] m_data;
    logic [1:0]                        m_status;
    logic                              m_found;

    sse_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (rd_data)
    );

    // hold operation and key, walk the store, drive the result register
    sse_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_opcode  (s_axis_tuser),
        .s_value   (s_axis_tdata),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_status  (m_status),
        .m_found   (m_found),
        .m_data    (m_data),
        .m_last    (m_axis_tlast),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .rd_data   (rd_data)
    );

    assign m_axis_tdata = m_data;
    assign m_axis_tuser = {m_found, m_status};

endmodule

`default_nettype wire

// ===== rtl/sse_checker.sv =====
// Port-level checks for the search stack engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sse_checker (
    input var logic        aclk,
    input var logic        aresetn,
    input var logic        s_axis_tvalid,
    input var logic        s_axis_tready,
    input var logic        m_axis_tvalid,
    input var logic        m_axis_tready,
    input var logic [31:0] m_axis_tdata,
    input var logic [2:0]  m_axis_tuser,
    input var logic        m_axis_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a new transaction always leaves the sequencer busy in the cycle after acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted while busy");

    // empty or full results end their transaction
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser[1:0] != sse_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error status without last");

    // a hit carries no entry and an ok status
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[2] |->
            (m_axis_tuser[1:0] == sse_pkg::ST_OK) && (m_axis_tdata == '0) && m_axis_tlast)
        else $error("found flag on a non-search result");

endmodule

bind search_stack_engine_top sse_checker u_sse_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
